// ===== rtl/ptbw_pkg.sv =====
// shared constants, codes and controller/datapath interface types
// for the pattern tile blit walker; no dependencies
package ptbw_pkg;

    // field widths
    localparam int COORD_BITS    = 16;
    localparam int PATTERN_MAX   = 4096;
    localparam int SRC_BITS      = 12;
    localparam int DIM_BITS      = 13;
    localparam int OFF_BITS      = 15;
    localparam int PEN_BITS      = 8;
    localparam int KIND_BITS     = 2;
    localparam int SIZE_BITS     = COORD_BITS + 1;
    localparam int WIDE_BITS     = COORD_BITS + 2;
    localparam int SUM_BITS      = COORD_BITS + 1;
    localparam int CNT_BITS      = $clog2(COORD_BITS);
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 16;
    localparam int IN_DATA_BITS  = 96;
    localparam int OUT_DATA_BITS = 104;

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_PRESENT = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PAT_W   = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PAT_H   = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SCROLL_X = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SCROLL_Y = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PEN     = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MASK    = 3'd6;

    // input op codes
    localparam logic OP_START = 1'b0;
    localparam logic OP_NEXT  = 1'b1;

    // command kinds
    localparam logic [KIND_BITS-1:0] KIND_SOLID      = 2'd0;
    localparam logic [KIND_BITS-1:0] KIND_LAYER      = 2'd1;
    localparam logic [KIND_BITS-1:0] KIND_LAYER_MASK = 2'd2;
    localparam logic [KIND_BITS-1:0] KIND_DIRECT     = 2'd3;

    // output register load selects
    localparam logic [1:0] EMIT_NONE    = 2'd0;
    localparam logic [1:0] EMIT_NOTHING = 2'd1;
    localparam logic [1:0] EMIT_SOLID   = 2'd2;
    localparam logic [1:0] EMIT_STEP    = 2'd3;

    typedef struct packed {
        logic       start;
        logic       latch;
        logic       setup;
        logic [1:0] emit;
    } t_cmd;

    typedef struct packed {
        logic empty;
        logic present;
        logic div_done;
        logic out_free;
    } t_status;

    // zero size counts as one, oversize counts as the largest pattern
    function automatic logic [DIM_BITS-1:0] clamp_dim(input logic [DIM_BITS-1:0] v);
        logic [DIM_BITS-1:0] r;
        if (v == '0) begin
            r = DIM_BITS'(1);
        end else if (v > DIM_BITS'(PATTERN_MAX)) begin
            r = DIM_BITS'(PATTERN_MAX);
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

// ===== rtl/pattern_tile_blit_walker.sv =====
// top level of the pattern tile blit walker: stream ports, field packing,
// controller and datapath; uses ptbw_pkg, ptbw_ctrl, ptbw_dpath
//
// Each input word is either a start (tuser 0) carrying a destination
// rectangle, or a next request (tuser 1); every accepted word gives exactly one
// output word. A start with an empty rectangle or with no pattern loaded gives
// its single result straight into the output register at acceptance. A start with a pattern runs two
// bit-serial remainder units (one per axis, one bit a cycle over the 16-bit
// origin magnitude) plus a setup state, so the first tile is registered once the
// output side is free after the setup state, and the input is held off during that time. Next
// requests step the tile walk in the acceptance cycle and are taken one per
// cycle while the output side takes words. Configuration writes are always
// ready and must only be issued while no request is being worked on.
module pattern_tile_blit_walker import ptbw_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // configuration write channel
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,
    // request stream
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    // rect_min_x[15:0], rect_min_y[31:16], rect_max_x[47:32], rect_max_y[63:48],
    // request_offset_x[78:64], request_offset_y[93:79], through_layer[94], zero[95]
    input  logic [IN_DATA_BITS-1:0]  s_axis_tdata,
    // op[0]
    input  logic                     s_axis_tuser,
    // command stream
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    // dest_x[15:0], dest_y[31:16], src_x[43:32], src_y[55:44], tile_width[72:56],
    // tile_height[89:73], command_kind[91:90], fill_pen[99:92], zero[103:100]
    output logic [OUT_DATA_BITS-1:0] m_axis_tdata,
    // last_tile
    output logic                     m_axis_tlast,
    // nothing_left[0]
    output logic                     m_axis_tuser
);

    t_cmd    w_cmd;
    t_status w_status;
    logic    w_in_ready;

    logic signed [COORD_BITS-1:0] w_dest_x;
    logic signed [COORD_BITS-1:0] w_dest_y;
    logic [SRC_BITS-1:0]          w_src_x;
    logic [SRC_BITS-1:0]          w_src_y;
    logic [SIZE_BITS-1:0]         w_tile_w;
    logic [SIZE_BITS-1:0]         w_tile_h;
    logic [KIND_BITS-1:0]         w_kind;
    logic [PEN_BITS-1:0]          w_pen;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = w_in_ready;

    // sequencing
    ptbw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_op    (s_axis_tuser),
        .o_in_ready (w_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // state, arithmetic and output register
    ptbw_dpath u_dpath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_valid),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_rect_min_x       (s_axis_tdata[15:0]),
        .i_rect_min_y       (s_axis_tdata[31:16]),
        .i_rect_max_x       (s_axis_tdata[47:32]),
        .i_rect_max_y       (s_axis_tdata[63:48]),
        .i_request_offset_x (s_axis_tdata[78:64]),
        .i_request_offset_y (s_axis_tdata[93:79]),
        .i_through_layer    (s_axis_tdata[94]),
        .i_cmd              (w_cmd),
        .o_status           (w_status),
        .i_out_ready        (m_axis_tready),
        .o_out_valid        (m_axis_tvalid),
        .o_dest_x           (w_dest_x),
        .o_dest_y           (w_dest_y),
        .o_src_x            (w_src_x),
        .o_src_y            (w_src_y),
        .o_tile_width       (w_tile_w),
        .o_tile_height      (w_tile_h),
        .o_command_kind     (w_kind),
        .o_fill_pen         (w_pen),
        .o_last_tile        (m_axis_tlast),
        .o_nothing_left     (m_axis_tuser)
    );

    // output word packing
    assign m_axis_tdata = {4'b0000, w_pen, w_kind, w_tile_h, w_tile_w,
                           w_src_y, w_src_x, w_dest_y, w_dest_x};

endmodule

// ===== rtl/ptbw_rem.sv =====
// bit-serial remainder unit: magnitude modulo pattern size, one bit a cycle,
// with wrap of negative dividends; uses ptbw_pkg
module ptbw_rem import ptbw_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic                  i_neg,
    input  logic [COORD_BITS-1:0] i_mag,
    input  logic [DIM_BITS-1:0]   i_div,
    output logic                  o_done,
    output logic [SRC_BITS-1:0]   o_rem
);

    logic                  r_busy;
    logic                  r_done;
    logic [CNT_BITS-1:0]   r_cnt;
    logic [COORD_BITS-1:0] r_dvd;
    logic [DIM_BITS-1:0]   r_rem;
    logic [DIM_BITS-1:0]   r_div;
    logic                  r_neg;

    logic [DIM_BITS:0]     w_trial;
    logic [DIM_BITS:0]     w_diff;
    logic [DIM_BITS-1:0]   n_rem;
    logic [DIM_BITS-1:0]   w_fix;

    // restoring step
    always_comb begin
        w_trial = {r_rem, r_dvd[COORD_BITS-1]};
        w_diff  = w_trial - {1'b0, r_div};
        if (w_trial >= {1'b0, r_div}) begin
            n_rem = w_diff[DIM_BITS-1:0];
        end else begin
            n_rem = w_trial[DIM_BITS-1:0];
        end
    end

    // negative dividend with a nonzero remainder wraps to size minus remainder
    always_comb begin
        w_fix = r_div - r_rem;
        if (r_neg && (r_rem != '0)) begin
            o_rem = w_fix[SRC_BITS-1:0];
        end else begin
            o_rem = r_rem[SRC_BITS-1:0];
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_BITS'(COORD_BITS - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - CNT_BITS'(1);
                end
            end
        end
    end

    // operand and partial remainder
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_mag;
            r_div <= i_div;
            r_neg <= i_neg;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[COORD_BITS-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;

endmodule

// ===== rtl/ptbw_ctrl.sv =====
// controller state machine: decodes accepted words and sequences a start
// through remainder, setup and first tile; uses ptbw_pkg
module ptbw_ctrl import ptbw_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_in_op,
    output logic    o_in_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_DIV   = 2'd1;
    localparam logic [1:0] S_SETUP = 2'd2;
    localparam logic [1:0] S_EMIT  = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    assign o_in_ready = (r_state == S_IDLE) && i_status.out_free;

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid && o_in_ready) begin
                    if (i_in_op == OP_NEXT) begin
                        o_cmd.emit = EMIT_STEP;
                    end else begin
                        o_cmd.start = 1'b1;
                        if (i_status.empty) begin
                            o_cmd.emit = EMIT_NOTHING;
                        end else if (!i_status.present) begin
                            o_cmd.emit = EMIT_SOLID;
                        end else begin
                            o_cmd.latch = 1'b1;
                            n_state     = S_DIV;
                        end
                    end
                end
            end
            S_DIV: begin
                if (i_status.div_done) begin
                    n_state = S_SETUP;
                end
            end
            S_SETUP: begin
                o_cmd.setup = 1'b1;
                n_state     = S_EMIT;
            end
            S_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = EMIT_STEP;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== rtl/ptbw_dpath.sv =====
// datapath: configuration registers, request state, tile stepping logic,
// two remainder units and the output register; uses ptbw_pkg, ptbw_rem
module ptbw_dpath import ptbw_pkg::*; (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]        i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]       i_cfg_data,
    input  logic signed [COORD_BITS-1:0]   i_rect_min_x,
    input  logic signed [COORD_BITS-1:0]   i_rect_min_y,
    input  logic signed [COORD_BITS-1:0]   i_rect_max_x,
    input  logic signed [COORD_BITS-1:0]   i_rect_max_y,
    input  logic [OFF_BITS-1:0]            i_request_offset_x,
    input  logic [OFF_BITS-1:0]            i_request_offset_y,
    input  logic                           i_through_layer,
    input  t_cmd                           i_cmd,
    output t_status                        o_status,
    input  logic                           i_out_ready,
    output logic                           o_out_valid,
    output logic signed [COORD_BITS-1:0]   o_dest_x,
    output logic signed [COORD_BITS-1:0]   o_dest_y,
    output logic [SRC_BITS-1:0]            o_src_x,
    output logic [SRC_BITS-1:0]            o_src_y,
    output logic [SIZE_BITS-1:0]           o_tile_width,
    output logic [SIZE_BITS-1:0]           o_tile_height,
    output logic [KIND_BITS-1:0]           o_command_kind,
    output logic [PEN_BITS-1:0]            o_fill_pen,
    output logic                           o_last_tile,
    output logic                           o_nothing_left
);

    // configuration registers
    logic                  r_present;
    logic [DIM_BITS-1:0]   r_pat_w;
    logic [DIM_BITS-1:0]   r_pat_h;
    logic [COORD_BITS-1:0] r_scroll_x;
    logic [COORD_BITS-1:0] r_scroll_y;
    logic [PEN_BITS-1:0]   r_pen;
    logic                  r_mask;

    // request state
    logic                  r_active;
    logic [COORD_BITS-1:0] r_min_x;
    logic [COORD_BITS-1:0] r_min_y;
    logic [COORD_BITS-1:0] r_max_x;
    logic [COORD_BITS-1:0] r_max_y;
    logic [SRC_BITS-1:0]   r_col_src_x;
    logic [COORD_BITS-1:0] r_next_x;
    logic [COORD_BITS-1:0] r_next_y;
    logic [SRC_BITS-1:0]   r_next_src_x;
    logic [SRC_BITS-1:0]   r_next_src_y;
    logic [DIM_BITS-1:0]   r_row_h;
    logic [KIND_BITS-1:0]  r_kind;
    logic [DIM_BITS-1:0]   r_lat_w;
    logic [DIM_BITS-1:0]   r_lat_h;

    // output register
    logic                  r_o_valid;
    logic [COORD_BITS-1:0] r_o_dest_x;
    logic [COORD_BITS-1:0] r_o_dest_y;
    logic [SRC_BITS-1:0]   r_o_src_x;
    logic [SRC_BITS-1:0]   r_o_src_y;
    logic [SIZE_BITS-1:0]  r_o_tw;
    logic [SIZE_BITS-1:0]  r_o_th;
    logic [KIND_BITS-1:0]  r_o_kind;
    logic [PEN_BITS-1:0]   r_o_pen;
    logic                  r_o_last;
    logic                  r_o_nothing;

    // start-side signals
    logic                  w_empty;
    logic [SIZE_BITS-1:0]  w_solid_w;
    logic [SIZE_BITS-1:0]  w_solid_h;
    logic [SUM_BITS-1:0]   w_sum_x;
    logic [SUM_BITS-1:0]   w_sum_y;
    logic [SUM_BITS-1:0]   w_neg_x;
    logic [SUM_BITS-1:0]   w_neg_y;
    logic [COORD_BITS-1:0] w_mag_x;
    logic [COORD_BITS-1:0] w_mag_y;
    logic [KIND_BITS-1:0]  w_kind;
    logic                  w_done_x;
    logic                  w_done_y;
    logic [SRC_BITS-1:0]   w_rem_x;
    logic [SRC_BITS-1:0]   w_rem_y;

    // setup signals
    logic [SIZE_BITS-1:0]  w_rows0;
    logic [DIM_BITS-1:0]   w_first_h;
    logic [DIM_BITS-1:0]   w_setup_h;

    // tile step signals
    logic [DIM_BITS-1:0]          w_w0;
    logic signed [WIDE_BITS-1:0]  w_nx;
    logic signed [WIDE_BITS-1:0]  w_ny;
    logic signed [WIDE_BITS-1:0]  w_mx;
    logic signed [WIDE_BITS-1:0]  w_my;
    logic signed [WIDE_BITS-1:0]  w_end_x;
    logic signed [WIDE_BITS-1:0]  w_end_y;
    logic signed [WIDE_BITS-1:0]  w_clip_w;
    logic signed [WIDE_BITS-1:0]  w_left_y;
    logic signed [WIDE_BITS-1:0]  w_lat_h_w;
    logic                         w_row_end;
    logic                         w_last;
    logic [SIZE_BITS-1:0]         w_tw;
    logic [COORD_BITS-1:0]        w_row_y;
    logic [DIM_BITS-1:0]          w_row_h_next;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_present  <= 1'b0;
            r_pat_w    <= DIM_BITS'(16);
            r_pat_h    <= DIM_BITS'(16);
            r_scroll_x <= '0;
            r_scroll_y <= '0;
            r_pen      <= '0;
            r_mask     <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_PRESENT:  r_present  <= i_cfg_data[0];
                CFG_PAT_W:    r_pat_w    <= i_cfg_data[DIM_BITS-1:0];
                CFG_PAT_H:    r_pat_h    <= i_cfg_data[DIM_BITS-1:0];
                CFG_SCROLL_X: r_scroll_x <= i_cfg_data[COORD_BITS-1:0];
                CFG_SCROLL_Y: r_scroll_y <= i_cfg_data[COORD_BITS-1:0];
                CFG_PEN:      r_pen      <= i_cfg_data[PEN_BITS-1:0];
                CFG_MASK:     r_mask     <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // start decode: empty check, solid size, pattern origin dividends
    always_comb begin
        w_empty   = (i_rect_min_x > i_rect_max_x) || (i_rect_min_y > i_rect_max_y);
        w_solid_w = {i_rect_max_x[COORD_BITS-1], i_rect_max_x}
                  - {i_rect_min_x[COORD_BITS-1], i_rect_min_x} + SIZE_BITS'(1);
        w_solid_h = {i_rect_max_y[COORD_BITS-1], i_rect_max_y}
                  - {i_rect_min_y[COORD_BITS-1], i_rect_min_y} + SIZE_BITS'(1);
        w_sum_x   = {r_scroll_x[COORD_BITS-1], r_scroll_x}
                  + {{(SUM_BITS-OFF_BITS){1'b0}}, i_request_offset_x};
        w_sum_y   = {r_scroll_y[COORD_BITS-1], r_scroll_y}
                  + {{(SUM_BITS-OFF_BITS){1'b0}}, i_request_offset_y};
        w_neg_x   = ~w_sum_x + SUM_BITS'(1);
        w_neg_y   = ~w_sum_y + SUM_BITS'(1);
        w_mag_x   = w_sum_x[SUM_BITS-1] ? w_neg_x[COORD_BITS-1:0] : w_sum_x[COORD_BITS-1:0];
        w_mag_y   = w_sum_y[SUM_BITS-1] ? w_neg_y[COORD_BITS-1:0] : w_sum_y[COORD_BITS-1:0];
        if (!i_through_layer) begin
            w_kind = KIND_DIRECT;
        end else if (r_mask) begin
            w_kind = KIND_LAYER_MASK;
        end else begin
            w_kind = KIND_LAYER;
        end
    end

    ptbw_rem u_rem_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.latch),
        .i_neg   (w_sum_x[SUM_BITS-1]),
        .i_mag   (w_mag_x),
        .i_div   (clamp_dim(r_pat_w)),
        .o_done  (w_done_x),
        .o_rem   (w_rem_x)
    );

    ptbw_rem u_rem_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.latch),
        .i_neg   (w_sum_y[SUM_BITS-1]),
        .i_mag   (w_mag_y),
        .i_div   (clamp_dim(r_pat_h)),
        .o_done  (w_done_y),
        .o_rem   (w_rem_y)
    );

    // first row height: rest of pattern, clipped to the rectangle
    always_comb begin
        w_rows0   = {r_max_y[COORD_BITS-1], r_max_y}
                  - {r_min_y[COORD_BITS-1], r_min_y} + SIZE_BITS'(1);
        w_first_h = r_lat_h - {1'b0, w_rem_y};
        if (w_rows0 < {{(SIZE_BITS-DIM_BITS){1'b0}}, w_first_h}) begin
            w_setup_h = w_rows0[DIM_BITS-1:0];
        end else begin
            w_setup_h = w_first_h;
        end
    end

    // tile step: clip at the right edge, detect row end and last tile
    always_comb begin
        w_w0      = r_lat_w - {1'b0, r_next_src_x};
        w_nx      = $signed({{(WIDE_BITS-COORD_BITS){r_next_x[COORD_BITS-1]}}, r_next_x});
        w_ny      = $signed({{(WIDE_BITS-COORD_BITS){r_next_y[COORD_BITS-1]}}, r_next_y});
        w_mx      = $signed({{(WIDE_BITS-COORD_BITS){r_max_x[COORD_BITS-1]}}, r_max_x});
        w_my      = $signed({{(WIDE_BITS-COORD_BITS){r_max_y[COORD_BITS-1]}}, r_max_y});
        w_end_x   = w_nx + $signed({{(WIDE_BITS-DIM_BITS){1'b0}}, w_w0})
                  - $signed(WIDE_BITS'(1));
        w_end_y   = w_ny + $signed({{(WIDE_BITS-DIM_BITS){1'b0}}, r_row_h})
                  - $signed(WIDE_BITS'(1));
        w_clip_w  = w_mx - w_nx + $signed(WIDE_BITS'(1));
        w_row_end = (w_end_x >= w_mx);
        w_last    = w_row_end && (w_end_y >= w_my);
        if (w_row_end) begin
            w_tw = w_clip_w[SIZE_BITS-1:0];
        end else begin
            w_tw = {{(SIZE_BITS-DIM_BITS){1'b0}}, w_w0};
        end
        // next row start and its height
        w_row_y   = r_next_y + {{(COORD_BITS-DIM_BITS){1'b0}}, r_row_h};
        w_left_y  = w_my - $signed({{(WIDE_BITS-COORD_BITS){w_row_y[COORD_BITS-1]}}, w_row_y})
                  + $signed(WIDE_BITS'(1));
        w_lat_h_w = $signed({{(WIDE_BITS-DIM_BITS){1'b0}}, r_lat_h});
        if (w_left_y < w_lat_h_w) begin
            w_row_h_next = w_left_y[DIM_BITS-1:0];
        end else begin
            w_row_h_next = r_lat_h;
        end
    end

    // active flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
        end else if (i_cmd.start) begin
            r_active <= 1'b0;
        end else if (i_cmd.setup) begin
            r_active <= 1'b1;
        end else if ((i_cmd.emit == EMIT_STEP) && r_active && w_last) begin
            r_active <= 1'b0;
        end
    end

    // request latch, setup and walk registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_min_x <= i_rect_min_x;
            r_min_y <= i_rect_min_y;
            r_max_x <= i_rect_max_x;
            r_max_y <= i_rect_max_y;
            r_kind  <= w_kind;
            r_lat_w <= clamp_dim(r_pat_w);
            r_lat_h <= clamp_dim(r_pat_h);
        end
        if (i_cmd.setup) begin
            r_col_src_x  <= w_rem_x;
            r_next_x     <= r_min_x;
            r_next_y     <= r_min_y;
            r_next_src_x <= w_rem_x;
            r_next_src_y <= w_rem_y;
            r_row_h      <= w_setup_h;
        end else if ((i_cmd.emit == EMIT_STEP) && r_active && !w_last) begin
            if (w_row_end) begin
                r_next_y     <= w_row_y;
                r_next_x     <= r_min_x;
                r_next_src_x <= r_col_src_x;
                r_next_src_y <= '0;
                r_row_h      <= w_row_h_next;
            end else begin
                r_next_x     <= r_next_x + {{(COORD_BITS-DIM_BITS){1'b0}}, w_w0};
                r_next_src_x <= '0;
            end
        end
    end

    // output word valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.emit != EMIT_NONE) begin
            r_o_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    // output word payload
    always_ff @(posedge i_clk) begin
        case (i_cmd.emit)
            EMIT_SOLID: begin
                r_o_dest_x  <= i_rect_min_x;
                r_o_dest_y  <= i_rect_min_y;
                r_o_src_x   <= '0;
                r_o_src_y   <= '0;
                r_o_tw      <= w_solid_w;
                r_o_th      <= w_solid_h;
                r_o_kind    <= KIND_SOLID;
                r_o_pen     <= r_pen;
                r_o_last    <= 1'b1;
                r_o_nothing <= 1'b0;
            end
            EMIT_STEP: begin
                if (r_active) begin
                    r_o_dest_x  <= r_next_x;
                    r_o_dest_y  <= r_next_y;
                    r_o_src_x   <= r_next_src_x;
                    r_o_src_y   <= r_next_src_y;
                    r_o_tw      <= w_tw;
                    r_o_th      <= {{(SIZE_BITS-DIM_BITS){1'b0}}, r_row_h};
                    r_o_kind    <= r_kind;
                    r_o_pen     <= '0;
                    r_o_last    <= w_last;
                    r_o_nothing <= 1'b0;
                end else begin
                    r_o_dest_x  <= '0;
                    r_o_dest_y  <= '0;
                    r_o_src_x   <= '0;
                    r_o_src_y   <= '0;
                    r_o_tw      <= '0;
                    r_o_th      <= '0;
                    r_o_kind    <= KIND_SOLID;
                    r_o_pen     <= '0;
                    r_o_last    <= 1'b0;
                    r_o_nothing <= 1'b1;
                end
            end
            EMIT_NOTHING: begin
                r_o_dest_x  <= '0;
                r_o_dest_y  <= '0;
                r_o_src_x   <= '0;
                r_o_src_y   <= '0;
                r_o_tw      <= '0;
                r_o_th      <= '0;
                r_o_kind    <= KIND_SOLID;
                r_o_pen     <= '0;
                r_o_last    <= 1'b0;
                r_o_nothing <= 1'b1;
            end
            default: begin
            end
        endcase
    end

    // status back to the controller
    always_comb begin
        o_status.empty    = w_empty;
        o_status.present  = r_present;
        o_status.div_done = w_done_x && w_done_y;
        o_status.out_free = !r_o_valid || i_out_ready;
    end

    assign o_out_valid    = r_o_valid;
    assign o_dest_x       = r_o_dest_x;
    assign o_dest_y       = r_o_dest_y;
    assign o_src_x        = r_o_src_x;
    assign o_src_y        = r_o_src_y;
    assign o_tile_width   = r_o_tw;
    assign o_tile_height  = r_o_th;
    assign o_command_kind = r_o_kind;
    assign o_fill_pen     = r_o_pen;
    assign o_last_tile    = r_o_last;
    assign o_nothing_left = r_o_nothing;

`ifndef SYNTH
    // a new word is only loaded when the previous one is gone or leaving
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit != EMIT_NONE) |-> (!r_o_valid || i_out_ready))
        else $error("output word overwritten before it was taken");

    // setup arms the walk for the first tile
    a_setup_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.setup |=> r_active)
        else $error("walk not active after setup");

    // pattern origin stays inside the latched pattern size
    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_done_x && w_done_y) |->
            (({1'b0, w_rem_x} < r_lat_w) && ({1'b0, w_rem_y} < r_lat_h)))
        else $error("pattern origin out of range");

    // a nothing-left word carries no command
    a_nothing_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_nothing) |-> ((r_o_tw == '0) && !r_o_last))
        else $error("nothing-left word carries a command");
`endif

endmodule

// ===== verif/pattern_tile_blit_walker_test.sv =====
// self-checking testbench for the pattern tile blit walker: drives request words,
// predicts every command word and compares it field by field
// depends on ptbw_pkg and the pattern_tile_blit_walker top level
module pattern_tile_blit_walker_test;
    import ptbw_pkg::*;

    localparam int RESET_CYCLES    = 12;
    localparam int SETTLE_CYCLES   = 24;
    localparam int STALL_LIMIT     = 5000;
    localparam int RANDOM_ITEMS    = 1050;
    localparam int PRESSURE_CYCLES = 300;
    localparam int MAX_PRINTED     = 100;

    // one blit command as it leaves the block
    typedef struct packed {
        logic [COORD_BITS-1:0] dest_x;
        logic [COORD_BITS-1:0] dest_y;
        logic [SRC_BITS-1:0]   src_x;
        logic [SRC_BITS-1:0]   src_y;
        logic [SIZE_BITS-1:0]  tile_w;
        logic [SIZE_BITS-1:0]  tile_h;
        logic [KIND_BITS-1:0]  kind;
        logic [PEN_BITS-1:0]   pen;
        logic                  last_tile;
        logic                  nothing_left;
    } t_tile_cmd;

    logic                     i_clk         = 1'b0;
    logic                     i_rst_n       = 1'b0;
    logic                     i_cfg_valid   = 1'b0;
    logic                     o_cfg_ready;
    logic [CFG_IDX_BITS-1:0]  i_cfg_index   = '0;
    logic [CFG_DATA_BITS-1:0] i_cfg_data    = '0;
    logic                     s_axis_tvalid = 1'b0;
    logic                     s_axis_tready;
    logic [IN_DATA_BITS-1:0]  s_axis_tdata  = '0;
    logic                     s_axis_tuser  = 1'b0;
    logic                     m_axis_tvalid;
    logic                     m_axis_tready = 1'b0;
    logic [OUT_DATA_BITS-1:0] m_axis_tdata;
    logic                     m_axis_tlast;
    logic                     m_axis_tuser;

    // configuration copy
    logic                cfg_present;
    logic [DIM_BITS-1:0] cfg_pat_w;
    logic [DIM_BITS-1:0] cfg_pat_h;
    logic [15:0]         cfg_scroll_x;
    logic [15:0]         cfg_scroll_y;
    logic [PEN_BITS-1:0] cfg_pen;
    logic                cfg_mask;

    // tile walk copy
    logic                 walk_active;
    longint               rect_x0, rect_y0, rect_x1, rect_y1;
    longint               col_src_x, cur_x, cur_y, cur_src_x, cur_src_y, cur_row_h;
    longint               lat_w, lat_h;
    logic [KIND_BITS-1:0] walk_kind;

    t_tile_cmd   queued_cmds[$];
    t_tile_cmd   latest_cmd;
    int          error_count   = 0;
    int          result_count  = 0;
    int          sent_count    = 0;
    int          stall_cycles  = 0;
    int          recv_hold     = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;

    pattern_tile_blit_walker dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    // ---------------------------------------------------------------- prediction

    function automatic longint clamp_size(logic [DIM_BITS-1:0] v);
        if (v == '0) return 1;
        if (v > PATTERN_MAX) return PATTERN_MAX;
        return longint'(v);
    endfunction

    // remainder that never goes negative
    function automatic longint wrap_mod(longint a, longint m);
        longint r;
        r = a % m;
        if (r < 0) r += m;
        return r;
    endfunction

    function automatic t_tile_cmd make_cmd(longint x, longint y, longint sx, longint sy,
                                           longint w, longint h, logic [KIND_BITS-1:0] kind,
                                           logic [PEN_BITS-1:0] pen, logic last);
        t_tile_cmd c;
        c.dest_x       = COORD_BITS'(x);
        c.dest_y       = COORD_BITS'(y);
        c.src_x        = SRC_BITS'(sx);
        c.src_y        = SRC_BITS'(sy);
        c.tile_w       = SIZE_BITS'(w);
        c.tile_h       = SIZE_BITS'(h);
        c.kind         = kind;
        c.pen          = pen;
        c.last_tile    = last;
        c.nothing_left = 1'b0;
        return c;
    endfunction

    function automatic t_tile_cmd empty_cmd();
        t_tile_cmd c;
        c = '0;
        c.nothing_left = 1'b1;
        return c;
    endfunction

    // emit the tile at the walk position, then step right or down a row
    function automatic t_tile_cmd walk_tile();
        longint    w, h;
        logic      row_end, last;
        t_tile_cmd c;
        w = lat_w - cur_src_x;
        h = cur_row_h;
        row_end = (cur_x + w - 1 >= rect_x1);
        if (row_end) w = rect_x1 - cur_x + 1;
        last = row_end && (cur_y + h - 1 >= rect_y1);
        c = make_cmd(cur_x, cur_y, cur_src_x, cur_src_y, w, h, walk_kind, '0, last);
        if (last) begin
            walk_active = 1'b0;
        end else if (row_end) begin
            cur_y += h;
            cur_x = rect_x0;
            cur_src_x = col_src_x;
            cur_src_y = 0;
            cur_row_h = lat_h;
            if (rect_y1 - cur_y + 1 < cur_row_h) cur_row_h = rect_y1 - cur_y + 1;
        end else begin
            cur_x += w;
            cur_src_x = 0;
        end
        return c;
    endfunction

    function automatic t_tile_cmd predict_command(logic op,
                                                  logic signed [15:0] x0, logic signed [15:0] y0,
                                                  logic signed [15:0] x1, logic signed [15:0] y1,
                                                  logic [OFF_BITS-1:0] offx,
                                                  logic [OFF_BITS-1:0] offy, logic layer);
        longint lx0, ly0, lx1, ly1;
        lx0 = longint'(x0);
        ly0 = longint'(y0);
        lx1 = longint'(x1);
        ly1 = longint'(y1);
        if (op == OP_NEXT) begin
            if (!walk_active) return empty_cmd();
            return walk_tile();
        end
        // a start always drops the walk in progress
        walk_active = 1'b0;
        if (lx0 > lx1 || ly0 > ly1) return empty_cmd();
        if (!cfg_present)
            return make_cmd(lx0, ly0, 0, 0, lx1 - lx0 + 1, ly1 - ly0 + 1,
                            KIND_SOLID, cfg_pen, 1'b1);
        lat_w = clamp_size(cfg_pat_w);
        lat_h = clamp_size(cfg_pat_h);
        col_src_x = wrap_mod(longint'($signed(cfg_scroll_x)) + longint'(offx), lat_w);
        cur_src_y = wrap_mod(longint'($signed(cfg_scroll_y)) + longint'(offy), lat_h);
        cur_src_x = col_src_x;
        rect_x0 = lx0;
        rect_y0 = ly0;
        rect_x1 = lx1;
        rect_y1 = ly1;
        cur_x = lx0;
        cur_y = ly0;
        cur_row_h = lat_h - cur_src_y;
        if (ly1 - ly0 + 1 < cur_row_h) cur_row_h = ly1 - ly0 + 1;
        walk_kind = layer ? (cfg_mask ? KIND_LAYER_MASK : KIND_LAYER) : KIND_DIRECT;
        walk_active = 1'b1;
        return walk_tile();
    endfunction

    // ---------------------------------------------------------------- checking

    task automatic report_mismatch(string msg);
        // keep the log short when the block is badly off
        if (error_count < MAX_PRINTED) $display("mismatch at result %0d: %s", result_count, msg);
        error_count++;
    endtask

    task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want) report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    // compare each command word with the oldest prediction
    always @(posedge i_clk) begin : check_results
        t_tile_cmd want;
        t_tile_cmd got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.dest_x       = m_axis_tdata[15:0];
            got.dest_y       = m_axis_tdata[31:16];
            got.src_x        = m_axis_tdata[43:32];
            got.src_y        = m_axis_tdata[55:44];
            got.tile_w       = m_axis_tdata[72:56];
            got.tile_h       = m_axis_tdata[89:73];
            got.kind         = m_axis_tdata[91:90];
            got.pen          = m_axis_tdata[99:92];
            got.last_tile    = m_axis_tlast;
            got.nothing_left = m_axis_tuser;
            if (queued_cmds.size() == 0) begin
                report_mismatch("command word with nothing expected");
            end else begin
                want = queued_cmds.pop_front();
                check_field("dest_x", 32'(got.dest_x), 32'(want.dest_x));
                check_field("dest_y", 32'(got.dest_y), 32'(want.dest_y));
                check_field("src_x", 32'(got.src_x), 32'(want.src_x));
                check_field("src_y", 32'(got.src_y), 32'(want.src_y));
                check_field("tile_width", 32'(got.tile_w), 32'(want.tile_w));
                check_field("tile_height", 32'(got.tile_h), 32'(want.tile_h));
                check_field("command_kind", 32'(got.kind), 32'(want.kind));
                check_field("fill_pen", 32'(got.pen), 32'(want.pen));
                check_field("last_tile", 32'(got.last_tile), 32'(want.last_tile));
                check_field("nothing_left", 32'(got.nothing_left), 32'(want.nothing_left));
            end
            result_count++;
        end
    end

    // receiver side: random stalls plus an optional long hold-off
    always @(posedge i_clk) begin
        if (recv_hold > 0) begin
            recv_hold--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // watchdog on cycles without any accepted word
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("watchdog: no word accepted for %0d cycles", stall_cycles);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ---------------------------------------------------------------- drivers

    // offer one request word, wait for it to be taken, predict its command
    task automatic send_word(logic op, logic [15:0] x0, logic [15:0] y0, logic [15:0] x1,
                             logic [15:0] y1, logic [OFF_BITS-1:0] offx,
                             logic [OFF_BITS-1:0] offy, logic layer);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, layer, offy, offx, y1, x1, y0, x0};
        s_axis_tuser  <= op;
        do @(posedge i_clk); while (!s_axis_tready);
        latest_cmd = predict_command(op, x0, y0, x1, y1, offx, offy, layer);
        queued_cmds.push_back(latest_cmd);
        sent_count++;
    endtask

    // next request with junk in the unused fields
    task automatic send_next();
        send_word(OP_NEXT, 16'($urandom()), 16'($urandom()), 16'($urandom()),
                  16'($urandom()), OFF_BITS'($urandom()), OFF_BITS'($urandom()),
                  1'($urandom()));
    endtask

    task automatic continue_walk(int max_next);
        int n;
        n = 0;
        while (!latest_cmd.last_tile && !latest_cmd.nothing_left && n < max_next) begin
            send_next();
            n++;
        end
    endtask

    task automatic walk_request(int x0, int y0, int x1, int y1, int offx, int offy,
                                logic layer, int max_next);
        send_word(OP_START, 16'(x0), 16'(y0), 16'(x1), 16'(y1), OFF_BITS'(offx),
                  OFF_BITS'(offy), layer);
        continue_walk(max_next);
    endtask

    // let every expected command drain, then give the block time to go idle
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (queued_cmds.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_PRESENT:  cfg_present  = data[0];
            CFG_PAT_W:    cfg_pat_w    = data[DIM_BITS-1:0];
            CFG_PAT_H:    cfg_pat_h    = data[DIM_BITS-1:0];
            CFG_SCROLL_X: cfg_scroll_x = data;
            CFG_SCROLL_Y: cfg_scroll_y = data;
            CFG_PEN:      cfg_pen      = data[PEN_BITS-1:0];
            CFG_MASK:     cfg_mask     = data[0];
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic configure(int present, int pw, int ph, int sx, int sy, int pen, int mask);
        write_reg(CFG_PRESENT, CFG_DATA_BITS'(present));
        write_reg(CFG_PAT_W, CFG_DATA_BITS'(pw));
        write_reg(CFG_PAT_H, CFG_DATA_BITS'(ph));
        write_reg(CFG_SCROLL_X, CFG_DATA_BITS'(sx));
        write_reg(CFG_SCROLL_Y, CFG_DATA_BITS'(sy));
        write_reg(CFG_PEN, CFG_DATA_BITS'(pen));
        write_reg(CFG_MASK, CFG_DATA_BITS'(mask));
    endtask

    // pattern sizes: mostly small, now and then the clamp corners
    function automatic logic [DIM_BITS-1:0] pick_size();
        case ($urandom_range(9))
            0: begin
                case ($urandom_range(4))
                    0: return DIM_BITS'(0);
                    1: return DIM_BITS'(1);
                    2: return DIM_BITS'(PATTERN_MAX);
                    3: return DIM_BITS'(PATTERN_MAX + 1);
                    default: return DIM_BITS'(8191);
                endcase
            end
            default: return DIM_BITS'($urandom_range(2, 24));
        endcase
    endfunction

    // ---------------------------------------------------------------- tests

    task automatic test_solid_fill();
        configure(0, 16, 16, 0, 0, 255, 0);
        send_word(OP_START, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 15'h0, 15'h0, 1'b1);
        send_word(OP_START, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 15'h7fff, 15'h7fff, 1'b0);
        // empty in x, then empty in y
        send_word(OP_START, 16'd5, 16'd0, 16'd4, 16'd0, 15'd0, 15'd0, 1'b0);
        send_word(OP_START, 16'd0, 16'hfffe, 16'd0, 16'hfffd, 15'd0, 15'd0, 1'b0);
        // next with no request open
        send_next();
    endtask

    task automatic test_pattern_walk();
        // negative scroll wraps into the pattern
        configure(1, 5, 3, -7, -2, 0, 0);
        walk_request(-3, -3, 4, 1, 1, 0, 1'b1, 20);
        // next after the request finished
        send_next();
        walk_request(0, 0, 6, 0, 0, 0, 1'b0, 5);
    endtask

    task automatic test_size_extremes();
        // zero width counts as one, oversize height as the largest pattern
        configure(1, 0, 8191, 32767, -32768, 0, 1);
        walk_request(-32768, -32768, -32766, 32767, 32767, 32767, 1'b1, 4);
        configure(1, PATTERN_MAX + 1, 1, 0, 0, 60, 1);
        // start while the previous walk is still open
        walk_request(-32768, 0, 32767, 0, 0, 0, 1'b0, 3);
        configure(1, PATTERN_MAX, PATTERN_MAX, -32768, 32767, 0, 0);
        walk_request(-32768, -32768, 32767, 32767, 32767, 0, 1'b1, 2);
    endtask

    task automatic test_config_mid_walk();
        // size and kind are held from the start, later writes wait for the next one
        configure(1, 3, 3, 0, 0, 90, 0);
        walk_request(0, 0, 5, 5, 0, 0, 1'b1, 1);
        write_reg(CFG_PAT_W, CFG_DATA_BITS'(7));
        write_reg(CFG_MASK, CFG_DATA_BITS'(1));
        write_reg(CFG_PRESENT, CFG_DATA_BITS'(0));
        continue_walk(10);
    endtask

    task automatic test_backpressure();
        configure(1, 2, 2, 1, 1, 0, 1);
        recv_hold = PRESSURE_CYCLES;
        walk_request(-10, 0, 9, 3, 0, 0, 1'b1, 40);
    endtask

    task automatic random_sequence();
        int w, h, x0, y0;
        if ($urandom_range(99) < 75) begin
            w = ($urandom_range(9) == 0) ? $urandom_range(1, 65536) : $urandom_range(1, 32);
            h = ($urandom_range(9) == 0) ? $urandom_range(1, 65536) : $urandom_range(1, 32);
            x0 = int'($urandom_range(65535)) - 32768;
            y0 = int'($urandom_range(65535)) - 32768;
            if (x0 + w > 32768) x0 = 32768 - w;
            if (y0 + h > 32768) y0 = 32768 - h;
            walk_request(x0, y0, x0 + w - 1, y0 + h - 1, int'($urandom_range(32767)),
                         int'($urandom_range(32767)), 1'($urandom_range(1)),
                         int'($urandom_range(60)));
            if (latest_cmd.last_tile && $urandom_range(4) == 0) send_next();
        end else begin
            // raw words: any op, any rectangle, often empty
            send_word(1'($urandom_range(1)), 16'($urandom()), 16'($urandom()),
                      16'($urandom()), 16'($urandom()), OFF_BITS'($urandom()),
                      OFF_BITS'($urandom()), 1'($urandom()));
        end
    endtask

    task automatic test_random(int n_items);
        int stop;
        stop = sent_count + n_items;
        while (sent_count < stop) begin
            configure(int'($urandom_range(4) != 0), int'(pick_size()), int'(pick_size()),
                      int'($urandom()), int'($urandom()), int'($urandom()),
                      int'($urandom_range(1)));
            repeat ($urandom_range(8, 16)) begin
                if (sent_count < stop) random_sequence();
            end
        end
    endtask

    // ---------------------------------------------------------------- sequence

    initial begin
        cfg_present  = 1'b0;
        cfg_pat_w    = DIM_BITS'(16);
        cfg_pat_h    = DIM_BITS'(16);
        cfg_scroll_x = '0;
        cfg_scroll_y = '0;
        cfg_pen      = '0;
        cfg_mask     = 1'b0;
        walk_active  = 1'b0;
        lat_w        = 1;
        lat_h        = 1;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 21;
        recv_idle_pct = 62;
        test_solid_fill();
        test_pattern_walk();
        test_size_extremes();
        test_config_mid_walk();
        test_backpressure();
        test_random(RANDOM_ITEMS / 3);

        send_idle_pct = 62;
        recv_idle_pct = 21;
        test_random(RANDOM_ITEMS / 3);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(RANDOM_ITEMS / 3);

        drain();
        if (queued_cmds.size() != 0) report_mismatch("commands still expected at the end");
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
